/* sv/sc2a_pkg.sv */
`timescale 1ns / 1ps
// sc2a_pkg: shared types, scan code constants and the set-1 character tables
// used by the scan code to ascii translator; no dependencies

package sc2a_pkg;

  localparam int unsigned CodeWidth = 8;
  localparam int unsigned CharWidth = 8;
  localparam int unsigned RomIdxWidth = 6;

  localparam logic [CodeWidth-1:0] CODE_EXT    = 8'hE0;
  localparam logic [CodeWidth-1:0] CODE_LSHIFT = 8'h2A;
  localparam logic [CodeWidth-1:0] CODE_RSHIFT = 8'h36;
  localparam logic [CodeWidth-1:0] CODE_CTL    = 8'h1D;
  localparam logic [CodeWidth-1:0] CODE_META   = 8'h38;
  localparam logic [CodeWidth-1:0] CODE_NUL    = 8'h03;
  localparam logic [CodeWidth-1:0] CODE_DEL    = 8'h35;
  localparam logic [CodeWidth-1:0] PLAIN_LEN   = 8'd58;
  localparam logic [CodeWidth-1:0] CTL_LEN     = 8'd51;
  localparam logic [CharWidth-1:0] CHAR_NUL    = 8'h00;
  localparam logic [CharWidth-1:0] CHAR_DEL    = 8'h7F;

  typedef struct packed {
    logic shift_held;
    logic control_held;
    logic meta_held;
    logic extended_pending;
  } flags_t;

  function automatic logic [6:0] plain_char(input logic [RomIdxWidth-1:0] idx);
    logic [6:0] ch;
    unique case (idx)
      6'd1:  ch = 7'h1B;  6'd2:  ch = 7'h31;  6'd3:  ch = 7'h32;  6'd4:  ch = 7'h33;
      6'd5:  ch = 7'h34;  6'd6:  ch = 7'h35;  6'd7:  ch = 7'h36;  6'd8:  ch = 7'h37;
      6'd9:  ch = 7'h38;  6'd10: ch = 7'h39;  6'd11: ch = 7'h30;  6'd12: ch = 7'h2D;
      6'd13: ch = 7'h3D;  6'd14: ch = 7'h08;  6'd15: ch = 7'h09;  6'd16: ch = 7'h71;
      6'd17: ch = 7'h77;  6'd18: ch = 7'h65;  6'd19: ch = 7'h72;  6'd20: ch = 7'h74;
      6'd21: ch = 7'h79;  6'd22: ch = 7'h75;  6'd23: ch = 7'h69;  6'd24: ch = 7'h6F;
      6'd25: ch = 7'h70;  6'd26: ch = 7'h5B;  6'd27: ch = 7'h5D;  6'd28: ch = 7'h0A;
      6'd30: ch = 7'h61;  6'd31: ch = 7'h73;  6'd32: ch = 7'h64;  6'd33: ch = 7'h66;
      6'd34: ch = 7'h67;  6'd35: ch = 7'h68;  6'd36: ch = 7'h6A;  6'd37: ch = 7'h6B;
      6'd38: ch = 7'h6C;  6'd39: ch = 7'h3B;  6'd40: ch = 7'h27;  6'd41: ch = 7'h60;
      6'd43: ch = 7'h5C;  6'd44: ch = 7'h7A;  6'd45: ch = 7'h78;  6'd46: ch = 7'h63;
      6'd47: ch = 7'h76;  6'd48: ch = 7'h62;  6'd49: ch = 7'h6E;  6'd50: ch = 7'h6D;
      6'd51: ch = 7'h2C;  6'd52: ch = 7'h2E;  6'd53: ch = 7'h2F;  6'd57: ch = 7'h20;
      default: ch = 7'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [6:0] shift_char(input logic [RomIdxWidth-1:0] idx);
    logic [6:0] ch;
    unique case (idx)
      6'd2:  ch = 7'h21;  6'd3:  ch = 7'h40;  6'd4:  ch = 7'h23;  6'd5:  ch = 7'h24;
      6'd6:  ch = 7'h25;  6'd7:  ch = 7'h5E;  6'd8:  ch = 7'h26;  6'd9:  ch = 7'h2A;
      6'd10: ch = 7'h28;  6'd11: ch = 7'h29;  6'd12: ch = 7'h5F;  6'd13: ch = 7'h2B;
      6'd14: ch = 7'h08;  6'd15: ch = 7'h09;  6'd16: ch = 7'h51;  6'd17: ch = 7'h57;
      6'd18: ch = 7'h45;  6'd19: ch = 7'h52;  6'd20: ch = 7'h54;  6'd21: ch = 7'h59;
      6'd22: ch = 7'h55;  6'd23: ch = 7'h49;  6'd24: ch = 7'h4F;  6'd25: ch = 7'h50;
      6'd26: ch = 7'h7B;  6'd27: ch = 7'h7D;  6'd28: ch = 7'h0A;  6'd30: ch = 7'h41;
      6'd31: ch = 7'h53;  6'd32: ch = 7'h44;  6'd33: ch = 7'h46;  6'd34: ch = 7'h47;
      6'd35: ch = 7'h48;  6'd36: ch = 7'h4A;  6'd37: ch = 7'h4B;  6'd38: ch = 7'h4C;
      6'd39: ch = 7'h3A;  6'd40: ch = 7'h22;  6'd41: ch = 7'h7E;  6'd43: ch = 7'h7C;
      6'd44: ch = 7'h5A;  6'd45: ch = 7'h58;  6'd46: ch = 7'h43;  6'd47: ch = 7'h56;
      6'd48: ch = 7'h42;  6'd49: ch = 7'h4E;  6'd50: ch = 7'h4D;  6'd51: ch = 7'h3C;
      6'd52: ch = 7'h3E;  6'd53: ch = 7'h3F;  6'd57: ch = 7'h20;
      default: ch = 7'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [6:0] ctl_char(input logic [RomIdxWidth-1:0] idx);
    logic [6:0] ch;
    unique case (idx)
      6'd12: ch = 7'h1F;  6'd14: ch = 7'h08;  6'd15: ch = 7'h09;  6'd16: ch = 7'h11;
      6'd17: ch = 7'h17;  6'd18: ch = 7'h05;  6'd19: ch = 7'h12;  6'd20: ch = 7'h14;
      6'd21: ch = 7'h19;  6'd22: ch = 7'h15;  6'd23: ch = 7'h09;  6'd24: ch = 7'h0F;
      6'd25: ch = 7'h10;  6'd26: ch = 7'h1B;  6'd27: ch = 7'h1D;  6'd28: ch = 7'h0A;
      6'd30: ch = 7'h01;  6'd31: ch = 7'h13;  6'd32: ch = 7'h04;  6'd33: ch = 7'h06;
      6'd34: ch = 7'h07;  6'd35: ch = 7'h08;  6'd36: ch = 7'h0A;  6'd37: ch = 7'h0B;
      6'd38: ch = 7'h0C;  6'd43: ch = 7'h1C;  6'd44: ch = 7'h1A;  6'd45: ch = 7'h18;
      6'd46: ch = 7'h03;  6'd47: ch = 7'h16;  6'd48: ch = 7'h02;  6'd49: ch = 7'h0E;
      6'd50: ch = 7'h0D;
      default: ch = 7'h00;
    endcase
    return ch;
  endfunction

endpackage

/* sv/sc2a_translate.sv */
`timescale 1ns / 1ps
// sc2a_translate: combinational decode of one scan code against the modifier flags
// depends on sc2a_pkg for flag type, code constants and character tables

module sc2a_translate import sc2a_pkg::*; (
  input  logic [CodeWidth-1:0] code,
  input  flags_t               flags,
  output flags_t               flags_next,
  output logic                 char_valid,
  output logic [CharWidth-1:0] char_code
);

  logic [CodeWidth-1:0]   key;
  logic [RomIdxWidth-1:0] idx;
  logic [6:0]             rom_char;

  assign key = {1'b0, code[CodeWidth-2:0]};
  assign idx = code[RomIdxWidth-1:0];

  always_comb begin
    if (flags.control_held) begin
      rom_char = ctl_char(idx);
    end else if (flags.shift_held) begin
      rom_char = shift_char(idx);
    end else begin
      rom_char = plain_char(idx);
    end
  end

  always_comb begin
    flags_next = flags;
    char_valid = 1'b0;
    char_code  = CHAR_NUL;
    priority if (flags.extended_pending) begin
      flags_next.extended_pending = 1'b0;
    end else if (code == CODE_EXT) begin
      flags_next.extended_pending = 1'b1;
    end else if (code[CodeWidth-1]) begin
      // break code
      priority if (key == CODE_LSHIFT || key == CODE_RSHIFT) begin
        flags_next.shift_held = 1'b0;
      end else if (key == CODE_CTL) begin
        flags_next.control_held = 1'b0;
      end else if (key == CODE_META) begin
        flags_next.meta_held = 1'b0;
      end else begin
        flags_next = flags;
      end
    end else if (code == CODE_LSHIFT || code == CODE_RSHIFT) begin
      flags_next.shift_held = 1'b1;
    end else if (code == CODE_CTL) begin
      flags_next.control_held = 1'b1;
    end else if (code == CODE_META) begin
      flags_next.meta_held = 1'b1;
    end else if (flags.shift_held && flags.control_held && code == CODE_NUL) begin
      char_valid = 1'b1;
      char_code  = CHAR_NUL;
    end else if (flags.shift_held && flags.control_held && code == CODE_DEL) begin
      char_valid = 1'b1;
      char_code  = CHAR_DEL;
    end else if ((flags.control_held && code < CTL_LEN) ||
                 (!flags.control_held && code < PLAIN_LEN)) begin
      // table entries stay below 0x80, so meta lands in the top bit
      char_valid = 1'b1;
      char_code  = {flags.meta_held, rom_char};
    end else begin
      char_valid = 1'b0;
    end
  end

endmodule

/* sv/scan_code_to_ascii.sv */
`timescale 1ns / 1ps
// scan_code_to_ascii: top level of the set-1 scan code to ascii translator
// depends on sc2a_pkg and sc2a_translate

// Takes one set-1 scan code per transaction and returns exactly one result per
// code: char_valid and char_code, with char_code zero when no character comes
// out. Shift, control and meta make/break codes and the 0xE0 prefix (which
// swallows the next code) update internal flags that reset clears. A code is
// taken every cycle while scan_ready is high; each accepted code passes from the
// input register through the table decode into the result register.
// When result_ready is low, the result register holds and one further code waits
// in the input register before scan_ready drops.

module scan_code_to_ascii import sc2a_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 scan_valid,
  output logic                 scan_ready,
  input  logic [CodeWidth-1:0] scan_code,
  output logic                 result_valid,
  input  logic                 result_ready,
  output logic                 char_valid,
  output logic [CharWidth-1:0] char_code
);

  logic                 stage_valid;
  logic [CodeWidth-1:0] stage_code;
  flags_t               flags;
  flags_t               flags_next;
  logic                 dec_valid;
  logic [CharWidth-1:0] dec_code;
  logic                 out_free;
  logic                 advance;

  assign out_free   = !result_valid || result_ready;
  assign advance    = stage_valid && out_free;
  assign scan_ready = !stage_valid || out_free;

  sc2a_translate u_translate (
    .code       (stage_code),
    .flags      (flags),
    .flags_next (flags_next),
    .char_valid (dec_valid),
    .char_code  (dec_code)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (scan_ready) begin
      stage_valid <= scan_valid;
    end
    if (scan_ready && scan_valid) begin
      stage_code <= scan_code;
    end
  end

  // modifier flags
  always_ff @(posedge clk) begin
    if (rst) begin
      flags <= '0;
    end else if (advance) begin
      flags <= flags_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_free) begin
      result_valid <= stage_valid;
    end
    if (advance) begin
      char_valid <= dec_valid;
      char_code  <= dec_code;
    end
  end

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps
// tb: self-checking bench for scan_code_to_ascii, predicts each character from its own
// copy of the modifier flags and set-1 maps; depends on sc2a_pkg and the DUT sources

typedef struct packed {
  bit       valid;
  bit [7:0] ch;
} char_result_t;

class char_scoreboard;
  localparam bit [7:0] BREAK_BIT   = 8'h80;
  localparam bit [7:0] META_OFFSET = 8'h80;

  bit [7:0]     plain_map [58];
  bit [7:0]     shift_map [58];
  bit [7:0]     ctrl_map  [51];
  bit           shift_on;
  bit           ctrl_on;
  bit           meta_on;
  bit           prefix_seen;
  char_result_t pending_chars [$];
  int           errors;

  function new();
    plain_map = '{8'h00, 8'h1B, "1", "2", "3", "4", "5", "6", "7", "8", "9", "0", "-", "=",
                  8'h08, 8'h09, "q", "w", "e", "r", "t", "y", "u", "i", "o", "p", "[", "]",
                  8'h0A, 8'h00, "a", "s", "d", "f", "g", "h", "j", "k", "l", ";", 8'h27,
                  8'h60, 8'h00, 8'h5C, "z", "x", "c", "v", "b", "n", "m", ",", ".", "/",
                  8'h00, 8'h00, 8'h00, " "};
    shift_map = '{8'h00, 8'h00, "!", "@", "#", "$", "%", "^", "&", "*", "(", ")", "_", "+",
                  8'h08, 8'h09, "Q", "W", "E", "R", "T", "Y", "U", "I", "O", "P", "{", "}",
                  8'h0A, 8'h00, "A", "S", "D", "F", "G", "H", "J", "K", "L", ":", 8'h22,
                  "~", 8'h00, "|", "Z", "X", "C", "V", "B", "N", "M", "<", ">", "?",
                  8'h00, 8'h00, 8'h00, " "};
    ctrl_map  = '{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
                  8'd31, 8'd0, 8'd8, 8'd9, 8'd17, 8'd23, 8'd5, 8'd18, 8'd20, 8'd25, 8'd21,
                  8'd9, 8'd15, 8'd16, 8'd27, 8'd29, 8'd10, 8'd0, 8'd1, 8'd19, 8'd4, 8'd6,
                  8'd7, 8'd8, 8'd10, 8'd11, 8'd12, 8'd0, 8'd0, 8'd0, 8'd0, 8'd28, 8'd26,
                  8'd24, 8'd3, 8'd22, 8'd2, 8'd14, 8'd13};
    shift_on    = 1'b0;
    ctrl_on     = 1'b0;
    meta_on     = 1'b0;
    prefix_seen = 1'b0;
    errors      = 0;
  endfunction

  function char_result_t translate(bit [7:0] code);
    char_result_t r;
    bit [7:0]     key;
    bit [7:0]     ch;
    r = '0;
    if (prefix_seen) begin
      prefix_seen = 1'b0;
      return r;
    end
    if (code == sc2a_pkg::CODE_EXT) begin
      prefix_seen = 1'b1;
      return r;
    end
    if ((code & BREAK_BIT) != 0) begin
      key = code ^ BREAK_BIT;
      if (key == sc2a_pkg::CODE_LSHIFT || key == sc2a_pkg::CODE_RSHIFT) shift_on = 1'b0;
      else if (key == sc2a_pkg::CODE_CTL) ctrl_on = 1'b0;
      else if (key == sc2a_pkg::CODE_META) meta_on = 1'b0;
      return r;
    end
    if (code == sc2a_pkg::CODE_LSHIFT || code == sc2a_pkg::CODE_RSHIFT) begin
      shift_on = 1'b1;
      return r;
    end
    if (code == sc2a_pkg::CODE_CTL) begin
      ctrl_on = 1'b1;
      return r;
    end
    if (code == sc2a_pkg::CODE_META) begin
      meta_on = 1'b1;
      return r;
    end
    // shift plus control: nul and del, meta not applied
    if (shift_on && ctrl_on) begin
      if (code == sc2a_pkg::CODE_NUL) begin
        r.valid = 1'b1;
        r.ch    = sc2a_pkg::CHAR_NUL;
        return r;
      end
      if (code == sc2a_pkg::CODE_DEL) begin
        r.valid = 1'b1;
        r.ch    = sc2a_pkg::CHAR_DEL;
        return r;
      end
    end
    if (ctrl_on) begin
      if (code >= sc2a_pkg::CTL_LEN) return r;
      ch = ctrl_map[code];
    end else if (shift_on) begin
      if (code >= sc2a_pkg::PLAIN_LEN) return r;
      ch = shift_map[code];
    end else begin
      if (code >= sc2a_pkg::PLAIN_LEN) return r;
      ch = plain_map[code];
    end
    if (meta_on) ch = ch + META_OFFSET;
    r.valid = 1'b1;
    r.ch    = ch;
    return r;
  endfunction

  function void note_code(bit [7:0] code);
    pending_chars.push_back(translate(code));
  endfunction

  function void check_char(bit valid, bit [7:0] ch);
    char_result_t exp;
    if (pending_chars.size() == 0) begin
      if (errors < 10)
        $display("unexpected transaction: char_valid=%0d char_code=%02h", valid, ch);
      errors++;
      return;
    end
    exp = pending_chars.pop_front();
    if (exp.valid != valid || exp.ch != ch) begin
      if (errors < 10)
        $display("mismatch: char_valid exp %0d got %0d, char_code exp %02h got %02h",
                 exp.valid, valid, exp.ch, ch);
      errors++;
    end
  endfunction

  function int pending_count();
    return pending_chars.size();
  endfunction
endclass

module tb;
  import sc2a_pkg::*;

  localparam int unsigned LIMIT      = 200000;
  localparam int          PHASE_ITEMS = 150;

  logic                 clk          = 1'b0;
  logic                 rst          = 1'b1;
  logic                 scan_valid   = 1'b0;
  logic                 scan_ready;
  logic [CodeWidth-1:0] scan_code    = '0;
  logic                 result_valid;
  logic                 result_ready = 1'b0;
  logic                 char_valid;
  logic [CharWidth-1:0] char_code;

  int          send_idle  = 0;
  int          recv_stall = 0;
  int unsigned cycles     = 0;
  char_scoreboard sb;

  scan_code_to_ascii DUT (
    .clk          (clk),
    .rst          (rst),
    .scan_valid   (scan_valid),
    .scan_ready   (scan_ready),
    .scan_code    (scan_code),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .char_valid   (char_valid),
    .char_code    (char_code)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      result_ready <= ($urandom_range(99) >= recv_stall);
      if (result_valid && result_ready) sb.check_char(char_valid, char_code);
    end
  end

  task automatic send_code(input logic [CodeWidth-1:0] c);
    scan_valid <= 1'b1;
    scan_code  <= c;
    @(posedge clk);
    while (!scan_ready) @(posedge clk);
    sb.note_code(c);
    if ($urandom_range(99) < send_idle) begin
      scan_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
  endtask

  function automatic logic [CodeWidth-1:0] modifier_code();
    case ($urandom_range(3))
      0:       return CODE_LSHIFT;
      1:       return CODE_RSHIFT;
      2:       return CODE_CTL;
      default: return CODE_META;
    endcase
  endfunction

  function automatic logic [CodeWidth-1:0] key_code();
    int r;
    r = $urandom_range(99);
    if (r < 8) return CODE_NUL;
    if (r < 16) return CODE_DEL;
    if (r < 90) return CodeWidth'($urandom_range(57));
    return CodeWidth'($urandom_range(127, 58));
  endfunction

  task automatic send_random();
    int r;
    r = $urandom_range(99);
    if (r < 15) begin
      send_code(modifier_code());
    end else if (r < 30) begin
      send_code(modifier_code() | 8'h80);
    end else if (r < 38) begin
      send_code(CODE_EXT);
      send_code($urandom_range(99) < 80 ? key_code() : CodeWidth'($urandom_range(255)));
    end else if (r < 85) begin
      send_code(key_code());
    end else if (r < 92) begin
      send_code(key_code() | 8'h80);
    end else begin
      send_code(CodeWidth'($urandom_range(255)));
    end
  endtask

  logic [CodeWidth-1:0] directed [25];

  initial begin
    sb = new();
    directed = '{8'h00, 8'h39, 8'h3A, 8'h7F, 8'hFF, CODE_LSHIFT, 8'h02, CODE_CTL,
                 CODE_NUL, CODE_DEL, 8'h33, 8'h32, CODE_META, CODE_NUL, 8'h01,
                 CODE_LSHIFT | 8'h80, CODE_CTL | 8'h80, 8'h29, 8'h3A, CODE_EXT,
                 CODE_LSHIFT, CODE_EXT, CODE_EXT, 8'h10, CODE_META | 8'h80};
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    foreach (directed[i]) send_code(directed[i]);
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin send_idle = 0;  recv_stall = 0;  end
        1:       begin send_idle = 67; recv_stall = 0;  end
        2:       begin send_idle = 0;  recv_stall = 67; end
        default: begin send_idle = 29; recv_stall = 29; end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) send_random();
    end
    scan_valid <= 1'b0;
    recv_stall = 0;
    while (sb.pending_count() > 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
